// ===== rtl/pcsc_pkg.sv =====
// Shared types, constants and lookup functions for the PNG chunk structure checker.
// No dependencies.
package pcsc_pkg;

    localparam logic [63:0] FILE_MAGIC = 64'h89504E470D0A1A0A;

    localparam logic [31:0] NAME_IHDR = 32'h49484452;
    localparam logic [31:0] NAME_IEND = 32'h49454E44;
    localparam logic [31:0] NAME_IDAT = 32'h49444154;
    localparam logic [31:0] NAME_PLTE = 32'h504C5445;
    localparam logic [31:0] NAME_BKGD = 32'h624B4744;
    localparam logic [31:0] NAME_CHRM = 32'h6348524D;
    localparam logic [31:0] NAME_GAMA = 32'h67414D41;
    localparam logic [31:0] NAME_HIST = 32'h68495354;
    localparam logic [31:0] NAME_ICCP = 32'h69434350;
    localparam logic [31:0] NAME_ITXT = 32'h69545874;
    localparam logic [31:0] NAME_PHYS = 32'h70485973;
    localparam logic [31:0] NAME_SBIT = 32'h73424954;
    localparam logic [31:0] NAME_SPLT = 32'h73504C54;
    localparam logic [31:0] NAME_SRGB = 32'h73524742;
    localparam logic [31:0] NAME_STER = 32'h73544552;
    localparam logic [31:0] NAME_TEXT = 32'h74455874;
    localparam logic [31:0] NAME_TIME = 32'h74494D45;
    localparam logic [31:0] NAME_TRNS = 32'h74524E53;
    localparam logic [31:0] NAME_ZTXT = 32'h7A545874;

    localparam logic [31:0] POS_MAX = 32'hFFFFFFFF;

    typedef enum logic [2:0] {
        ST_CHUNK_LISTED = 3'd0,
        ST_IHDR_FOUND   = 3'd1,
        ST_PARSE_OK     = 3'd2,
        ST_BAD_SIG      = 3'd3,
        ST_NO_IHDR      = 3'd4,
        ST_DOUBLE_IHDR  = 3'd5,
        ST_UNKNOWN      = 3'd6,
        ST_IEND_NO_IDAT = 3'd7
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] chunk_offset;
        logic [31:0] chunk_length;
        logic [31:0] chunk_type;
        logic [31:0] chunk_crc;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
        logic    done;
    } parse_out_t;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [5:0] sh;
        sh = 6'(7 - idx) << 3;
        return 8'(FILE_MAGIC >> sh);
    endfunction

    function automatic logic name_known(input logic [31:0] name);
        logic hit;
        case (name) inside
            NAME_IHDR, NAME_IEND, NAME_IDAT, NAME_PLTE, NAME_BKGD, NAME_CHRM,
            NAME_GAMA, NAME_HIST, NAME_ICCP, NAME_ITXT, NAME_PHYS, NAME_SBIT,
            NAME_SPLT, NAME_SRGB, NAME_STER, NAME_TEXT, NAME_TIME, NAME_TRNS,
            NAME_ZTXT: hit = 1'b1;
            default:   hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ===== rtl/pcsc_byte_if.sv =====
// Byte stream channel: valid/ready handshake carrying one file byte per beat.
// No dependencies.
interface pcsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== rtl/pcsc_chunk_if.sv =====
// Result channel: valid/ready handshake carrying one chunk report per beat.
// No dependencies.
interface pcsc_chunk_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] chunk_offset;
    logic [31:0] chunk_length;
    logic [31:0] chunk_type;
    logic [31:0] chunk_crc;

    modport source (output valid, output status, output chunk_offset, output chunk_length,
                    output chunk_type, output chunk_crc, input ready);
    modport sink   (input valid, input status, input chunk_offset, input chunk_length,
                    input chunk_type, input chunk_crc, output ready);
endinterface

// ===== rtl/pcsc_parser.sv =====
// Chunk framing state machine: signature check, field shifting, classification.
// Depends on pcsc_pkg.
module pcsc_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    output pcsc_pkg::parse_out_t  pout
);

    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CRC,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  count_reg, count_next;
    logic        mismatch_reg, mismatch_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] start_reg, start_next;
    logic        hdr_reg, hdr_next;
    logic        idat_reg, idat_next;

    logic        res_valid;
    pcsc_pkg::status_t res_status;
    logic        bad_byte;

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        mismatch_next = mismatch_reg;
        length_next   = length_reg;
        type_next     = type_reg;
        crc_next      = crc_reg;
        remain_next   = remain_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        hdr_next      = hdr_reg;
        idat_next     = idat_reg;
        res_valid     = 1'b0;
        res_status    = pcsc_pkg::ST_CHUNK_LISTED;
        bad_byte      = (data_byte != pcsc_pkg::sig_byte(count_reg));

        if (step && phase_reg != PH_DONE)
        begin
            if (pos_reg != pcsc_pkg::POS_MAX)
            begin
                pos_next = pos_reg + 32'd1;
            end
            case (phase_reg)
                PH_SIG:
                begin
                    mismatch_next = mismatch_reg | bad_byte;
                    if (count_reg == 3'd7)
                    begin
                        count_next = 3'd0;
                        if (mismatch_next)
                        begin
                            phase_next = PH_DONE;
                            res_valid  = 1'b1;
                            res_status = pcsc_pkg::ST_BAD_SIG;
                        end
                        else
                        begin
                            phase_next = PH_LEN;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + 3'd1;
                    end
                end
                PH_LEN:
                begin
                    if (count_reg == 3'd0)
                    begin
                        start_next = pos_reg;
                    end
                    length_next = {length_reg[23:0], data_byte};
                    if (count_reg == 3'd3)
                    begin
                        count_next = 3'd0;
                        phase_next = PH_TYPE;
                    end
                    else
                    begin
                        count_next = count_reg + 3'd1;
                    end
                end
                PH_TYPE:
                begin
                    type_next = {type_reg[23:0], data_byte};
                    if (count_reg == 3'd3)
                    begin
                        count_next  = 3'd0;
                        remain_next = length_reg;
                        phase_next  = (length_reg == 32'd0) ? PH_CRC : PH_DATA;
                    end
                    else
                    begin
                        count_next = count_reg + 3'd1;
                    end
                end
                PH_DATA:
                begin
                    remain_next = remain_reg - 32'd1;
                    if (remain_reg == 32'd1)
                    begin
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    crc_next = {crc_reg[23:0], data_byte};
                    if (count_reg == 3'd3)
                    begin
                        count_next = 3'd0;
                        phase_next = PH_LEN;
                        res_valid  = 1'b1;
                        if (!hdr_reg)
                        begin
                            if (type_reg == pcsc_pkg::NAME_IHDR)
                            begin
                                hdr_next   = 1'b1;
                                res_status = pcsc_pkg::ST_IHDR_FOUND;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                                res_status = pcsc_pkg::ST_NO_IHDR;
                            end
                        end
                        else if (type_reg == pcsc_pkg::NAME_IHDR)
                        begin
                            phase_next = PH_DONE;
                            res_status = pcsc_pkg::ST_DOUBLE_IHDR;
                        end
                        else if (type_reg == pcsc_pkg::NAME_IEND)
                        begin
                            phase_next = PH_DONE;
                            res_status = idat_reg ? pcsc_pkg::ST_PARSE_OK
                                                  : pcsc_pkg::ST_IEND_NO_IDAT;
                        end
                        else if (type_reg == pcsc_pkg::NAME_IDAT)
                        begin
                            idat_next = 1'b1;
                        end
                        else if (!pcsc_pkg::name_known(type_reg))
                        begin
                            phase_next = PH_DONE;
                            res_status = pcsc_pkg::ST_UNKNOWN;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + 3'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SIG;
            count_reg    <= 3'd0;
            mismatch_reg <= 1'b0;
            length_reg   <= 32'd0;
            type_reg     <= 32'd0;
            crc_reg      <= 32'd0;
            remain_reg   <= 32'd0;
            pos_reg      <= 32'd0;
            start_reg    <= 32'd0;
            hdr_reg      <= 1'b0;
            idat_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            mismatch_reg <= mismatch_next;
            length_reg   <= length_next;
            type_reg     <= type_next;
            crc_reg      <= crc_next;
            remain_reg   <= remain_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            hdr_reg      <= hdr_next;
            idat_reg     <= idat_next;
        end
    end

    always_comb
    begin
        pout.valid       = res_valid;
        pout.done        = (phase_reg == PH_DONE);
        pout.data.status = res_status;
        if (res_status == pcsc_pkg::ST_BAD_SIG)
        begin
            pout.data.chunk_offset = 32'd0;
            pout.data.chunk_length = 32'd0;
            pout.data.chunk_type   = 32'd0;
            pout.data.chunk_crc    = 32'd0;
        end
        else
        begin
            pout.data.chunk_offset = start_reg;
            pout.data.chunk_length = length_reg;
            pout.data.chunk_type   = type_reg;
            pout.data.chunk_crc    = crc_next;
        end
    end

endmodule

// ===== rtl/pcsc_out_buf.sv =====
// Two-entry result buffer (output register plus skid) driving the result channel.
// Depends on pcsc_pkg and pcsc_chunk_if.
module pcsc_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pcsc_pkg::result_t    push_data,
    output logic                 space,
    pcsc_chunk_if.source         chunks
);

    logic              head_valid_reg, head_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    pcsc_pkg::result_t head_reg, head_next;
    pcsc_pkg::result_t skid_reg, skid_next;
    logic              pop;

    assign pop   = head_valid_reg && chunks.ready;
    assign space = !skid_valid_reg;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg || pop)
            begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            head_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign chunks.valid        = head_valid_reg;
    assign chunks.status       = head_reg.status;
    assign chunks.chunk_offset = head_reg.chunk_offset;
    assign chunks.chunk_length = head_reg.chunk_length;
    assign chunks.chunk_type   = head_reg.chunk_type;
    assign chunks.chunk_crc    = head_reg.chunk_crc;

endmodule

// ===== rtl/png_chunk_structure_checker.sv =====
// Top level of the PNG chunk structure checker: input register, parser, result buffer.
// Depends on pcsc_pkg, pcsc_byte_if, pcsc_chunk_if, pcsc_parser, pcsc_out_buf.
//
//   channel      role    beat
//   file_bytes   sink    one file byte (data_byte)
//   chunks       source  status, chunk_offset, chunk_length, chunk_type, chunk_crc
//
// One byte per cycle sustained while the result buffer has space; a result becomes
// valid after its last CRC byte passes the input register, then the result register.
// The result side holds two entries, so input keeps flowing while one result waits.
// After an error or IEND every byte is taken and dropped until rst_n.
// rst_n clears all control state at once; no clearing pass.
module png_chunk_structure_checker (
    input  logic         clk,
    input  logic         rst_n,
    pcsc_byte_if.sink    file_bytes,
    pcsc_chunk_if.source chunks
);

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           byte_reg;
    logic                 space;
    logic                 proceed;
    logic                 accept;
    pcsc_pkg::parse_out_t pout;

    assign proceed          = in_valid_reg && space;
    assign file_bytes.ready = !in_valid_reg || space;
    assign accept           = file_bytes.valid && file_bytes.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (proceed)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= file_bytes.data_byte;
        end
    end

    pcsc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (proceed),
        .data_byte (byte_reg),
        .pout      (pout)
    );

    pcsc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pout.valid),
        .push_data (pout.data),
        .space     (space),
        .chunks    (chunks)
    );

    a_no_result_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        pout.done |-> !pout.valid)
        else $error("result produced after parse end");

    a_bad_sig_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        chunks.valid && chunks.status == 3'(pcsc_pkg::ST_BAD_SIG) |->
            chunks.chunk_offset == 32'd0 && chunks.chunk_length == 32'd0 &&
            chunks.chunk_type == 32'd0 && chunks.chunk_crc == 32'd0)
        else $error("bad signature result carries nonzero fields");

    a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !proceed |=> in_valid_reg && $stable(byte_reg))
        else $error("held input byte lost");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !space |-> !file_bytes.ready)
        else $error("input taken while result buffer full");

endmodule

// ===== bench/tb_png_chunk_structure_checker.sv =====
// Testbench for png_chunk_structure_checker: streams a PNG byte sequence and checks chunk
// reports against a behavioral tracker of the parser.
// Depends on pcsc_pkg, pcsc_byte_if, pcsc_chunk_if and the png_chunk_structure_checker RTL.
module tb_png_chunk_structure_checker;

    typedef enum logic [2:0] {P_SIG, P_LEN, P_TYPE, P_DATA, P_CRC, P_DONE} parse_phase_t;
    typedef enum {START_GOOD, START_BAD_SIG, START_NO_IHDR} start_kind_t;
    typedef enum {END_OK, END_NO_IDAT, END_DOUBLE_IHDR, END_UNKNOWN, END_OPEN} end_kind_t;

    localparam logic [31:0] NAME_HLST_TYPO = 32'h686C5354;
    localparam logic [31:0] LISTED_NAMES [19] = '{
        pcsc_pkg::NAME_IHDR, pcsc_pkg::NAME_IEND, pcsc_pkg::NAME_IDAT, pcsc_pkg::NAME_PLTE,
        pcsc_pkg::NAME_BKGD, pcsc_pkg::NAME_CHRM, pcsc_pkg::NAME_GAMA, pcsc_pkg::NAME_HIST,
        pcsc_pkg::NAME_ICCP, pcsc_pkg::NAME_ITXT, pcsc_pkg::NAME_PHYS, pcsc_pkg::NAME_SBIT,
        pcsc_pkg::NAME_SPLT, pcsc_pkg::NAME_SRGB, pcsc_pkg::NAME_STER, pcsc_pkg::NAME_TEXT,
        pcsc_pkg::NAME_TIME, pcsc_pkg::NAME_TRNS, pcsc_pkg::NAME_ZTXT
    };
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_TARGET = 1350;

    logic clk = 1'b0;
    logic rst_n;

    pcsc_byte_if  file_bytes ();
    pcsc_chunk_if chunks ();

    png_chunk_structure_checker i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .file_bytes (file_bytes),
        .chunks     (chunks)
    );

    always #10 clk = ~clk;

    // parse tracker state
    parse_phase_t m_phase;
    logic [2:0]   m_count;
    logic         m_sig_bad;
    logic [31:0]  m_len;
    logic [31:0]  m_type;
    logic [31:0]  m_crc;
    logic [31:0]  m_remaining;
    logic [31:0]  m_pos;
    logic [31:0]  m_start;
    logic         m_hdr_done;
    logic         m_idat_seen;

    pcsc_pkg::result_t pending_reports [$];
    int      reports_predicted = 0;
    int      bytes_sent = 0;
    int      errors = 0;

    start_kind_t start_kind;
    end_kind_t   end_kind;
    int          burst_left = 0;
    bit          steady = 1'b0;

    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;
    int rdy_mode = 0;
    int rdy_left = 0;

    function automatic bit name_listed(input logic [31:0] name);
        foreach (LISTED_NAMES[i])
            if (LISTED_NAMES[i] == name)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic pcsc_pkg::status_t classify_chunk();
        if (!m_hdr_done)
        begin
            if (m_type == pcsc_pkg::NAME_IHDR)
            begin
                m_hdr_done = 1'b1;
                return pcsc_pkg::ST_IHDR_FOUND;
            end
            m_phase = P_DONE;
            return pcsc_pkg::ST_NO_IHDR;
        end
        if (m_type == pcsc_pkg::NAME_IHDR)
        begin
            m_phase = P_DONE;
            return pcsc_pkg::ST_DOUBLE_IHDR;
        end
        if (m_type == pcsc_pkg::NAME_IEND)
        begin
            m_phase = P_DONE;
            return m_idat_seen ? pcsc_pkg::ST_PARSE_OK : pcsc_pkg::ST_IEND_NO_IDAT;
        end
        if (m_type == pcsc_pkg::NAME_IDAT)
            m_idat_seen = 1'b1;
        if (name_listed(m_type))
            return pcsc_pkg::ST_CHUNK_LISTED;
        m_phase = P_DONE;
        return pcsc_pkg::ST_UNKNOWN;
    endfunction

    task automatic track_chunk_byte(input logic [7:0] b);
        logic [31:0]       pos;
        pcsc_pkg::result_t r;
        pos = m_pos;
        if (m_phase == P_DONE)
            return;
        if (m_pos != pcsc_pkg::POS_MAX)
            m_pos = m_pos + 32'd1;
        case (m_phase)
            P_SIG:
            begin
                if (b != pcsc_pkg::FILE_MAGIC[8 * (7 - int'(m_count)) +: 8])
                    m_sig_bad = 1'b1;
                if (m_count == 3'd7)
                begin
                    m_count = '0;
                    if (m_sig_bad)
                    begin
                        m_phase = P_DONE;
                        r = '0;
                        r.status = pcsc_pkg::ST_BAD_SIG;
                        pending_reports.push_back(r);
                        reports_predicted++;
                    end
                    else
                        m_phase = P_LEN;
                end
                else
                    m_count++;
            end
            P_LEN:
            begin
                if (m_count == 3'd0)
                    m_start = pos;
                m_len = {m_len[23:0], b};
                if (m_count == 3'd3)
                begin
                    m_count = '0;
                    m_phase = P_TYPE;
                end
                else
                    m_count++;
            end
            P_TYPE:
            begin
                m_type = {m_type[23:0], b};
                if (m_count == 3'd3)
                begin
                    m_count = '0;
                    m_remaining = m_len;
                    m_phase = (m_len == 32'd0) ? P_CRC : P_DATA;
                end
                else
                    m_count++;
            end
            P_DATA:
            begin
                m_remaining = m_remaining - 32'd1;
                if (m_remaining == 32'd0)
                    m_phase = P_CRC;
            end
            P_CRC:
            begin
                m_crc = {m_crc[23:0], b};
                if (m_count == 3'd3)
                begin
                    m_count = '0;
                    m_phase = P_LEN;
                    r.status = classify_chunk();
                    r.chunk_offset = m_start;
                    r.chunk_length = m_len;
                    r.chunk_type = m_type;
                    r.chunk_crc = m_crc;
                    pending_reports.push_back(r);
                    reports_predicted++;
                end
                else
                    m_count++;
            end
            default:
                m_phase = P_DONE;
        endcase
    endtask

    task automatic flag_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        errors++;
    endtask

    task automatic check_report();
        pcsc_pkg::result_t want;
        if (pending_reports.size() == 0)
        begin
            flag_error("report with none pending", chunks.chunk_type, 32'h0);
            return;
        end
        want = pending_reports.pop_front();
        if (chunks.status != want.status)
            flag_error("status", chunks.status, want.status);
        if (chunks.chunk_offset != want.chunk_offset)
            flag_error("chunk_offset", chunks.chunk_offset, want.chunk_offset);
        if (chunks.chunk_length != want.chunk_length)
            flag_error("chunk_length", chunks.chunk_length, want.chunk_length);
        if (chunks.chunk_type != want.chunk_type)
            flag_error("chunk_type", chunks.chunk_type, want.chunk_type);
        if (chunks.chunk_crc != want.chunk_crc)
            flag_error("chunk_crc", chunks.chunk_crc, want.chunk_crc);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && chunks.valid && chunks.ready)
            check_report();
    end

    // receiver: stall pattern is redrawn at random; long hold on request
    always @(posedge clk)
    begin
        if (hold_left == 0 && holds_asked > holds_served)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            chunks.ready <= 1'b0;
        end
        else
        begin
            if (rdy_left == 0)
            begin
                rdy_mode = $urandom_range(0, 3);
                rdy_left = $urandom_range(20, 200);
            end
            rdy_left--;
            case (rdy_mode)
                0:       chunks.ready <= 1'b1;
                1:       chunks.ready <= 1'($urandom_range(0, 1));
                2:       chunks.ready <= ($urandom_range(0, 3) == 0);
                default: chunks.ready <= (rdy_left % 8) < 5;
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                file_bytes.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        file_bytes.valid <= 1'b1;
        file_bytes.data_byte <= b;
        @(posedge clk);
        while (!file_bytes.ready)
            @(posedge clk);
        track_chunk_byte(b);
        bytes_sent++;
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            send_byte(w[8 * i +: 8]);
    endtask

    task automatic send_chunk(input logic [31:0] len, input logic [31:0] name,
                              input logic [31:0] crc);
        send_word(len);
        send_word(name);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
        send_word(crc);
    endtask

    task automatic wait_reports_drained();
        file_bytes.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
    endtask

    function automatic bit parse_over();
        return m_phase == P_DONE;
    endfunction

    function automatic logic [31:0] random_length();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return $urandom_range(0, 8);
        if (pick < 19)
            return $urandom_range(9, 64);
        return $urandom_range(65, 400);
    endfunction

    function automatic logic [31:0] random_crc();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // listed names other than IHDR and IEND; IDAT only when the ending allows it
    function automatic logic [31:0] any_listed_name();
        int k;
        k = $urandom_range(3, 18);
        if (end_kind != END_NO_IDAT && $urandom_range(0, 3) == 0)
            return pcsc_pkg::NAME_IDAT;
        return LISTED_NAMES[k];
    endfunction

    function automatic logic [31:0] stray_name();
        logic [31:0] n;
        case ($urandom_range(0, 3))
            0:       n = NAME_HLST_TYPO;
            1:       n = pcsc_pkg::NAME_IEND ^ 32'h0000_0020;
            default: n = $urandom;
        endcase
        while (name_listed(n))
            n = $urandom;
        return n;
    endfunction

    task automatic test_signature();
        int k;
        logic [7:0] flip;
        k = $urandom_range(0, 7);
        flip = 8'($urandom_range(1, 255));
        for (int i = 7; i >= 0; i--)
        begin
            if (start_kind != START_BAD_SIG)
                send_byte(pcsc_pkg::FILE_MAGIC[8 * i +: 8]);
            else if (k == 0)
                send_byte(~pcsc_pkg::FILE_MAGIC[8 * i +: 8]);
            else if (i == k)
                send_byte(pcsc_pkg::FILE_MAGIC[8 * i +: 8] ^ flip);
            else
                send_byte(pcsc_pkg::FILE_MAGIC[8 * i +: 8]);
        end
    endtask

    task automatic test_first_chunk();
        if (parse_over())
            return;
        if (start_kind == START_NO_IHDR)
        begin
            if ($urandom_range(0, 1))
                send_chunk(random_length(), any_listed_name(), random_crc());
            else
                send_chunk(random_length(), stray_name(), random_crc());
            return;
        end
        send_chunk(32'd0, pcsc_pkg::NAME_IHDR, 32'hFFFF_FFFF);
        send_chunk(32'd0, pcsc_pkg::NAME_TEXT, 32'h0000_0000);
    endtask

    task automatic test_chunk_stream(input int byte_target, input int report_target);
        while (!parse_over() && (bytes_sent < byte_target || reports_predicted < report_target))
            send_chunk(random_length(), any_listed_name(), random_crc());
    endtask

    // receiver holds off while short chunks keep coming: the result side fills up
    task automatic test_output_stall();
        if (parse_over())
            return;
        steady = 1'b1;
        holds_asked++;
        repeat (12) send_chunk(32'd0, any_listed_name(), random_crc());
        steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        if (parse_over())
            return;
        wait_reports_drained();
        burst_left = 0;
    endtask

    task automatic test_terminal();
        if (parse_over())
            return;
        case (end_kind)
            END_OK:
            begin
                if (!m_idat_seen)
                    send_chunk(random_length(), pcsc_pkg::NAME_IDAT, random_crc());
                send_chunk(random_length(), pcsc_pkg::NAME_IEND, random_crc());
            end
            END_NO_IDAT:     send_chunk(random_length(), pcsc_pkg::NAME_IEND, random_crc());
            END_DOUBLE_IHDR: send_chunk(random_length(), pcsc_pkg::NAME_IHDR, random_crc());
            END_UNKNOWN:     send_chunk(random_length(), stray_name(), random_crc());
            default:
            begin
                // chunk too long to finish: no report may appear
                send_word($urandom_range(0, 1) ? 32'hFFFF_FFFF : {1'b1, 31'($urandom)});
                send_word(any_listed_name());
                repeat (20) send_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // trailing bytes: at least 40, topped up to the item count when the parse ended early
    task automatic test_bytes_after_end();
        int extra;
        extra = (bytes_sent < ITEM_TARGET - 40) ? ITEM_TARGET - bytes_sent : 40;
        repeat (extra) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        file_bytes.valid = 1'b0;
        file_bytes.data_byte = 8'h00;
        chunks.ready = 1'b0;
        m_phase = P_SIG;
        m_count = '0;
        m_sig_bad = 1'b0;
        m_len = '0;
        m_type = '0;
        m_crc = '0;
        m_remaining = '0;
        m_pos = '0;
        m_start = '0;
        m_hdr_done = 1'b0;
        m_idat_seen = 1'b0;
        case ($urandom_range(0, 9))
            0:       start_kind = START_BAD_SIG;
            1:       start_kind = START_NO_IHDR;
            default: start_kind = START_GOOD;
        endcase
        case ($urandom_range(0, 4))
            0:       end_kind = END_OK;
            1:       end_kind = END_NO_IDAT;
            2:       end_kind = END_DOUBLE_IHDR;
            3:       end_kind = END_UNKNOWN;
            default: end_kind = END_OPEN;
        endcase
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_signature();
        test_first_chunk();
        test_chunk_stream(600, 0);
        test_output_stall();
        test_drain_pause();
        test_chunk_stream(1330, 40);
        test_terminal();
        test_bytes_after_end();

        wait_reports_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #(20 * 300000);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== png_chunk_structure_checker.f =====
rtl/pcsc_pkg.sv
rtl/pcsc_byte_if.sv
rtl/pcsc_chunk_if.sv
rtl/pcsc_parser.sv
rtl/pcsc_out_buf.sv
rtl/png_chunk_structure_checker.sv
bench/tb_png_chunk_structure_checker.sv
